>>> rtl/sidx_pkg.sv
package sidx_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_ENTRY  = 2'd1;
  localparam logic [1:0] KIND_TRUNC  = 2'd2;

  // Entry word masks
  localparam logic [31:0] TOP_BIT_MASK  = 32'h8000_0000;
  localparam logic [31:0] SIZE_MASK     = 32'h7fff_ffff;
  localparam logic [31:0] SAP_TYPE_MASK = 32'h7000_0000;
  localparam logic [31:0] SAP_DELTA_MASK = 32'h0fff_ffff;

  // Queue between the parser and the result stage
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Parse phases
  typedef enum logic [3:0] {
    PH_VF     = 4'd0,
    PH_REFID  = 4'd1,
    PH_TSCALE = 4'd2,
    PH_EPT    = 4'd3,
    PH_FOFF   = 4'd4,
    PH_RSVD   = 4'd5,
    PH_COUNT  = 4'd6,
    PH_ENT0   = 4'd7,
    PH_ENT1   = 4'd8,
    PH_ENT2   = 4'd9,
    PH_DONE   = 4'd10
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       box_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [7:0]  version;
    logic [23:0] flags;
    logic [63:0] value_a;
    logic [63:0] value_b;
    logic [31:0] value_c;
    logic [31:0] value_d;
    logic [15:0] reference_count;
    logic        entry_is_index;
    logic        starts_with_sap;
    logic [2:0]  sap_type;
  } out_item_t;

  // What one input byte leaves for the result stage
  typedef struct packed {
    logic      has_main;
    out_item_t main;
    logic      trunc;
  } q_entry_t;

endpackage

>>> rtl/sidx_front.sv
module sidx_front import sidx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     push_o,
  output q_entry_t push_entry_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  bif_q, bif_d;
  logic [63:0] shift_q, shift_d;
  logic [7:0]  version_q, version_d;
  logic [23:0] flags_q, flags_d;
  logic [31:0] ref_id_q, ref_id_d;
  logic [31:0] tscale_q, tscale_d;
  logic [63:0] ept_q, ept_d;
  logic [63:0] foff_q, foff_d;
  logic [15:0] left_q, left_d;
  logic [31:0] word0_q, word0_d;
  logic [31:0] dur_q, dur_d;

  logic [3:0]  len;
  logic        field_done;
  logic [63:0] shift_new;
  logic [31:0] w;
  logic [15:0] left_dec;
  q_entry_t    ent;

  // Field length of the current phase
  always_comb begin
    case (phase_q)
      PH_EPT, PH_FOFF:   len = (version_q == 8'd0) ? 4'd4 : 4'd8;
      PH_RSVD, PH_COUNT: len = 4'd2;
      default:           len = 4'd4;
    endcase
  end

  assign shift_new  = {shift_q[55:0], item_i.data_byte};
  assign w          = shift_new[31:0];
  assign field_done = ({1'b0, bif_q} + 4'd1) >= len;
  assign left_dec   = left_q - 16'd1;

  // Byte parser
  always_comb begin
    phase_d   = phase_q;
    bif_d     = bif_q;
    shift_d   = shift_q;
    version_d = version_q;
    flags_d   = flags_q;
    ref_id_d  = ref_id_q;
    tscale_d  = tscale_q;
    ept_d     = ept_q;
    foff_d    = foff_q;
    left_d    = left_q;
    word0_d   = word0_q;
    dur_d     = dur_q;
    ent       = '0;

    if (accept_i) begin
      if (phase_q != PH_DONE) begin
        if (field_done) begin
          bif_d   = 3'd0;
          shift_d = '0;
          case (phase_q)
            PH_VF: begin
              version_d = w[31:24];
              flags_d   = w[23:0];
              phase_d   = PH_REFID;
            end
            PH_REFID: begin
              ref_id_d = w;
              phase_d  = PH_TSCALE;
            end
            PH_TSCALE: begin
              tscale_d = w;
              phase_d  = PH_EPT;
            end
            PH_EPT: begin
              ept_d   = shift_new;
              phase_d = PH_FOFF;
            end
            PH_FOFF: begin
              foff_d  = shift_new;
              phase_d = PH_RSVD;
            end
            PH_RSVD: begin
              phase_d = PH_COUNT;
            end
            PH_COUNT: begin
              left_d                     = w[15:0];
              ent.has_main               = 1'b1;
              ent.main.kind              = KIND_HEADER;
              ent.main.last              = (w[15:0] == 16'd0);
              ent.main.version           = version_q;
              ent.main.flags             = flags_q;
              ent.main.value_a           = ept_q;
              ent.main.value_b           = foff_q;
              ent.main.value_c           = ref_id_q;
              ent.main.value_d           = tscale_q;
              ent.main.reference_count   = w[15:0];
              phase_d = (w[15:0] != 16'd0) ? PH_ENT0 : PH_DONE;
            end
            PH_ENT0: begin
              word0_d = w;
              phase_d = PH_ENT1;
            end
            PH_ENT1: begin
              dur_d   = w;
              phase_d = PH_ENT2;
            end
            PH_ENT2: begin
              left_d                   = left_dec;
              ent.has_main             = 1'b1;
              ent.main.kind            = KIND_ENTRY;
              ent.main.last            = (left_dec == 16'd0);
              ent.main.value_a         = {32'd0, dur_q};
              ent.main.value_b         = {32'd0, word0_q & SIZE_MASK};
              ent.main.value_c         = w & SAP_DELTA_MASK;
              ent.main.entry_is_index  = |(word0_q & TOP_BIT_MASK);
              ent.main.starts_with_sap = |(w & TOP_BIT_MASK);
              ent.main.sap_type        = w[30:28];
              phase_d = (left_dec != 16'd0) ? PH_ENT0 : PH_DONE;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end else begin
          bif_d   = bif_q + 3'd1;
          shift_d = shift_new;
        end
      end

      // Box end restarts parsing; flag truncation if not complete
      if (item_i.box_end) begin
        ent.trunc = (phase_d != PH_DONE);
        phase_d   = PH_VF;
        bif_d     = 3'd0;
        shift_d   = '0;
      end
    end
  end

  assign push_o       = accept_i && (ent.has_main || ent.trunc);
  assign push_entry_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_VF;
      bif_q     <= '0;
      shift_q   <= '0;
      version_q <= '0;
      flags_q   <= '0;
      ref_id_q  <= '0;
      tscale_q  <= '0;
      ept_q     <= '0;
      foff_q    <= '0;
      left_q    <= '0;
      word0_q   <= '0;
      dur_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      bif_q     <= bif_d;
      shift_q   <= shift_d;
      version_q <= version_d;
      flags_q   <= flags_d;
      ref_id_q  <= ref_id_d;
      tscale_q  <= tscale_d;
      ept_q     <= ept_d;
      foff_q    <= foff_d;
      left_q    <= left_d;
      word0_q   <= word0_d;
      dur_q     <= dur_d;
    end
  end

endmodule

>>> rtl/sidx_queue.sv
module sidx_queue import sidx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t push_entry_i,
  input  logic     pop_i,
  output q_entry_t head_o,
  output logic     empty_o,
  output logic     full_o
);

  q_entry_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == QCntW'(0));
  assign full_o  = (count_q == QCntW'(QDepth));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (do_push && !do_pop) begin
        count_q <= count_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

>>> rtl/sidx_back.sv
module sidx_back import sidx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  q_entry_t  head_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_stall_i
);

  logic      valid_q, valid_d;
  logic      pend_q, pend_d;
  out_item_t item_q, item_d;
  out_item_t trunc_item;
  logic      load;

  // Fixed truncation result
  always_comb begin
    trunc_item      = '0;
    trunc_item.kind = KIND_TRUNC;
    trunc_item.last = 1'b1;
  end

  assign load = !valid_q || !out_stall_i;

  // Output register refill
  always_comb begin
    valid_d = valid_q;
    pend_d  = pend_q;
    item_d  = item_q;
    pop_o   = 1'b0;
    if (load) begin
      if (pend_q) begin
        item_d  = trunc_item;
        valid_d = 1'b1;
        pend_d  = 1'b0;
      end else if (!empty_i) begin
        pop_o   = 1'b1;
        valid_d = 1'b1;
        if (head_i.has_main) begin
          item_d = head_i.main;
          pend_d = head_i.trunc;
        end else begin
          item_d = trunc_item;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

>>> rtl/segment_index_box_parser.sv
// A result passes through the queue (written when its byte is accepted) and then
// the output register before it is shown.
// One byte per cycle is taken while the queue is not full; a box-end byte that
// also closes a field can give two results: its own result, then a truncation.
// A four-item queue between parser and output register absorbs output stalls.
// Reset (rst_ni low, asynchronous) returns the parser to the version/flags phase
// and empties the queue and output register.
module segment_index_box_parser import sidx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  in_item_t  in_item_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  output out_item_t out_item_o,
  input  logic      out_stall_i
);

  logic     accept;
  logic     push, pop, empty, full;
  q_entry_t push_entry, head;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  sidx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (in_item_i),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  sidx_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_o       (head),
    .empty_o      (empty),
    .full_o       (full)
  );

  sidx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule
